/* rtl/core/hic_pkg.sv */
package hic_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [3:0] OFF_ROOT    = 4'd0;
  localparam logic [3:0] OFF_MASTER0 = 4'd1;
  localparam logic [3:0] OFF_MASTER1 = 4'd2;
  localparam logic [3:0] OFF_MASTER2 = 4'd3;
  localparam logic [3:0] OFF_MASTER3 = 4'd4;
  localparam logic [3:0] OFF_BLK_SEL = 4'd5;
  localparam logic [3:0] OFF_STATUS  = 4'd6;
  localparam logic [3:0] OFF_CONFIG  = 4'd7;
  localparam logic [3:0] OFF_LIVE    = 4'd8;

  // setup and config write bits
  localparam int SETUP_LEVEL_BIT = 0;
  localparam int SETUP_MASK_FE   = 1;
  localparam int SETUP_MASK_RE   = 2;
  localparam int CFG_CLEAR_BIT   = 3;
  localparam int CFG_STORE_BIT   = 7;
  localparam logic [2:0] SETUP_RESET = 3'b110;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SEL_WR,
    CMD_CFG_WR,
    CMD_READ,
    CMD_UPDATE
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [4:0] line_block;
    logic [7:0] line_levels;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
  } out_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] off;
    logic [7:0] data;
    logic [4:0] blk;
    logic [7:0] levels;
  } item_t;

  function automatic logic level_active(logic [2:0] setup, logic level);
    return level ? !setup[SETUP_MASK_RE] : !setup[SETUP_MASK_FE];
  endfunction

endpackage

/* rtl/core/hic_ram.sv */
module hic_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/hic_front.sv */
module hic_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hic_pkg::in_t    in_data_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output hic_pkg::item_t  item_o
);
  import hic_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      cls;
  logic       push, pop;

  // decode the operation into a back-end command
  always_comb begin
    cls.off    = in_data_i.reg_offset;
    cls.data   = in_data_i.write_data;
    cls.blk    = in_data_i.line_block;
    cls.levels = in_data_i.line_levels;
    case (in_data_i.operation)
      OP_WRITE: begin
        if (in_data_i.reg_offset == OFF_BLK_SEL) cls.cmd = CMD_SEL_WR;
        else if (in_data_i.reg_offset == OFF_CONFIG) cls.cmd = CMD_CFG_WR;
        else cls.cmd = CMD_NOP;
      end
      OP_READ:   cls.cmd = CMD_READ;
      OP_UPDATE: cls.cmd = CMD_UPDATE;
      default:   cls.cmd = CMD_NOP;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end
endmodule

/* rtl/core/hic_back.sv */
module hic_back #(
  parameter int NUM_LINES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  hic_pkg::item_t  item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hic_pkg::out_t   out_data_o
);
  import hic_pkg::*;

  localparam int ROWS = (NUM_LINES + 7) / 8;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic        state_q;
  item_t       cur_q;
  logic [7:0]  pending_q [32];
  logic [7:0]  prev_q [32];
  logic [31:0] nz_q, nz_next;
  logic [ROWS-1:0] row_valid_q;
  logic [4:0]  sel_blk_q, sel_blk_d;
  logic [2:0]  sel_line_q, sel_line_d;
  logic        out_valid_q;
  out_t        out_q;

  logic        pop, fire, out_free, row_ok, ram_we;
  logic [4:0]  pop_blk, cur_blk;
  logic [23:0] ram_rdata, row, new_row;
  logic [7:0]  vm, pend_old, prev_old, pend_new, prev_new, nw, setbits, rd;
  logic [2:0]  s;

  function automatic logic [7:0] blk_mask(logic [4:0] blk);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i] = (int'(blk) * 8 + i) < NUM_LINES;
    end
    return m;
  endfunction

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop      = item_valid_i && item_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = (state_q == ST_EXEC) && out_free;
  assign pop_blk  = (item_i.cmd == CMD_UPDATE) ? item_i.blk : sel_blk_q;
  assign cur_blk  = (cur_q.cmd == CMD_UPDATE) ? cur_q.blk : sel_blk_q;

  hic_ram #(.WIDTH(24), .DEPTH(ROWS), .AW(AW)) u_setup_ram (
    .clk_i   (clk_i),
    .we_i    (fire && ram_we),
    .waddr_i (AW'(cur_blk)),
    .wdata_i (new_row),
    .re_i    (pop),
    .raddr_i (AW'(pop_blk)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    row_ok   = int'(cur_blk) < ROWS;
    row      = (row_ok && row_valid_q[AW'(cur_blk)]) ? ram_rdata : {8{SETUP_RESET}};
    vm       = blk_mask(cur_blk);
    pend_old = pending_q[cur_blk];
    prev_old = prev_q[cur_blk];
    nw       = cur_q.levels & vm;
    for (int i = 0; i < 8; i++) begin
      s = row[3*i +: 3];
      if (!vm[i]) setbits[i] = 1'b0;
      else if (s[SETUP_LEVEL_BIT]) setbits[i] = level_active(s, nw[i]);
      else setbits[i] = (!prev_old[i] && nw[i] && !s[SETUP_MASK_RE]) ||
                        (prev_old[i] && !nw[i] && !s[SETUP_MASK_FE]);
    end
    s          = cur_q.data[2:0];
    pend_new   = pend_old;
    prev_new   = prev_old;
    new_row    = row;
    ram_we     = 1'b0;
    rd         = '0;
    sel_blk_d  = sel_blk_q;
    sel_line_d = sel_line_q;
    case (cur_q.cmd)
      CMD_SEL_WR: sel_blk_d = cur_q.data[4:0];
      CMD_CFG_WR: begin
        sel_line_d = cur_q.data[6:4];
        if (cur_q.data[CFG_STORE_BIT] && vm[sel_line_d]) begin
          ram_we = 1'b1;
          new_row[3*int'(sel_line_d) +: 3] = s;
          if (cur_q.data[CFG_CLEAR_BIT]) pend_new[sel_line_d] = 1'b0;
          if (s[SETUP_LEVEL_BIT] && level_active(s, prev_old[sel_line_d])) begin
            pend_new[sel_line_d] = 1'b1;
          end
        end
      end
      CMD_READ: begin
        case (cur_q.off)
          OFF_ROOT: begin
            rd = {3'b000, |nz_q[31:24], |nz_q[23:16], |nz_q[15:8], |nz_q[7:0], |nz_q};
          end
          OFF_MASTER0: rd = nz_q[7:0];
          OFF_MASTER1: rd = nz_q[15:8];
          OFF_MASTER2: rd = nz_q[23:16];
          OFF_MASTER3: rd = nz_q[31:24];
          OFF_BLK_SEL: rd = {3'b000, sel_blk_q};
          OFF_STATUS:  rd = pend_old;
          OFF_CONFIG: begin
            rd = {1'b0, sel_line_q, 1'b0,
                  vm[sel_line_q] ? row[3*int'(sel_line_q) +: 3] : 3'b000};
          end
          OFF_LIVE:    rd = prev_old;
          default:     rd = '0;
        endcase
      end
      CMD_UPDATE: begin
        pend_new = pend_old | setbits;
        prev_new = nw;
      end
      default: ;
    endcase
    nz_next          = nz_q;
    nz_next[cur_blk] = |pend_new;
  end

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= item_i;
    if (fire) begin
      out_q.read_data <= rd;
      out_q.irq_out   <= |nz_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      nz_q        <= '0;
      row_valid_q <= '0;
      sel_blk_q   <= '0;
      sel_line_q  <= '0;
      for (int b = 0; b < 32; b++) begin
        pending_q[b] <= '0;
        prev_q[b]    <= '0;
      end
    end else begin
      if (pop) state_q <= ST_EXEC;
      else if (fire) state_q <= ST_IDLE;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (fire) begin
        pending_q[cur_blk] <= pend_new;
        prev_q[cur_blk]    <= prev_new;
        nz_q               <= nz_next;
        sel_blk_q          <= sel_blk_d;
        sel_line_q         <= sel_line_d;
        if (ram_we) row_valid_q[AW'(cur_blk)] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

/* rtl/core/hierarchical_interrupt_controller.sv */
// interrupt controller with root / master / block status tree
// input channel (in_valid_i / in_ready_o / in_data_i): one beat is a bus
//   write, a bus read or a line level update for one block of eight lines
// output channel (out_valid_o / out_ready_i / out_data_o): exactly one beat
//   per input beat, in order; read_data holds the read byte (zero for writes
//   and updates), irq_out the summary interrupt after that beat
// path: a beat accepted into the queue is popped into the back end, which reads
//   its setup row and then executes into the output register once it is free
// the back end takes a new beat only after the last one has executed: it reads
//   the line setup row from its memory in its idle state and executes in exec
// a 2-deep queue parts the decode front from the back end, so input beats
//   keep landing while a result waits in the output register
// reset: all pending bits, stored levels and selects clear; every line reads
//   as edge mode with both masks set (per-row valid bits, no clearing pass)
// receiver stall: the output register holds its beat, the back end stops,
//   then the queue fills and in_ready_o drops
module hierarchical_interrupt_controller #(
  parameter int NUM_LINES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hic_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hic_pkg::out_t out_data_o
);
  import hic_pkg::*;

  // decoded beat between the front and back parts
  item_t item;
  logic  item_valid, item_ready;

  // front: accept and classify into commands, buffered in a short queue
  hic_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // back: status tree, setup memory and output register
  hic_back #(.NUM_LINES(NUM_LINES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );
endmodule
